// ===== src/vp9_rtp_descriptor_parser_macros.svh =====
// assertion helpers for the vp9 rtp descriptor parser
// both expect clk and rst_n in scope
`ifndef VP9_RTP_DESCRIPTOR_PARSER_MACROS_SVH
`define VP9_RTP_DESCRIPTOR_PARSER_MACROS_SVH

// same-cycle implication
`define VRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/vrd_pkg.sv =====
package vrd_pkg;

  // descriptor limits
  localparam logic [1:0]  MAX_REF_DIFFS    = 2'd3;
  localparam logic [15:0] MAX_PACKET_BYTES = 16'hFFFF;

  // record queue between parser and output stage, power of two deep
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // flag_bits positions
  localparam int FB_I = 11;
  localparam int FB_L = 9;
  localparam int FB_F = 8;
  localparam int FB_V = 5;
  localparam int FB_M = 4;
  localparam int FB_U = 3;
  localparam int FB_D = 2;
  localparam int FB_Y = 1;
  localparam int FB_G = 0;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_DIFFS = 2'd2;

  // record kinds
  localparam logic KIND_RES  = 1'b0;
  localparam logic KIND_DESC = 1'b1;

  // parse phases
  typedef enum logic [12:0] {
    PH_FLAG    = 13'b0000000000001,
    PH_PID     = 13'b0000000000010,
    PH_PIDEXT  = 13'b0000000000100,
    PH_LAYER   = 13'b0000000001000,
    PH_PDIFF   = 13'b0000000010000,
    PH_TL0     = 13'b0000000100000,
    PH_SS      = 13'b0000001000000,
    PH_RES     = 13'b0000010000000,
    PH_GOFN    = 13'b0000100000000,
    PH_GOFENT  = 13'b0001000000000,
    PH_GOFSKIP = 13'b0010000000000,
    PH_PAYLOAD = 13'b0100000000000,
    PH_HALT    = 13'b1000000000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        record_kind;
    logic [1:0]  status;
    logic [11:0] flag_bits;
    logic [14:0] picture_id;
    logic [2:0]  temporal_id;
    logic [2:0]  spatial_id;
    logic [7:0]  tl0_index;
    logic [6:0]  reference_diff;
    logic [2:0]  layer_number;
    logic [7:0]  gof_frames;
    logic [15:0] first_value;
    logic [15:0] second_value;
  } rec_t;

  // records produced by one byte, in order
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              nonempty;
    logic              room;
  } qstat_t;

endpackage

// ===== src/vrd_front.sv =====
module vrd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  vrd_pkg::in_t  in_data,
  output vrd_pkg::push_t push
);
  import vrd_pkg::*;

  typedef struct packed {
    phase_t      phase;
    logic [11:0] flags;
    logic [14:0] pic;
    logic [5:0]  ids;
    logic [7:0]  tl0;
    logic [6:0]  diff;
    logic [1:0]  dcnt;
    logic [2:0]  ltot;
    logic [2:0]  lcnt;
    logic [1:0]  sbc;
    logic [23:0] sacc;
    logic [7:0]  gtot;
    logic [7:0]  gcnt;
    logic [1:0]  skip;
    logic [15:0] bpos;
    logic [15:0] hdr;
    logic [1:0]  err;
  } pstate_t;

  pstate_t st_r, st_nxt, st_clr;
  rec_t    res_rec, desc_rec;
  logic    res_emit;
  logic [7:0] b;

  assign b = in_data.data_byte;

  // cleared parse state, waiting for a flag byte
  always_comb begin
    st_clr       = '0;
    st_clr.phase = PH_FLAG;
  end

  // per-byte parse step
  always_comb begin
    st_nxt   = st_r;
    res_emit = 1'b0;
    res_rec  = '0;
    desc_rec = '0;

    // restart on first byte
    if (in_data.first_byte) begin
      st_nxt       = '0;
      st_nxt.phase = PH_FLAG;
    end
    if (st_nxt.bpos < MAX_PACKET_BYTES) begin
      st_nxt.bpos = st_nxt.bpos + 16'd1;
    end

    case (st_nxt.phase)
      PH_FLAG: begin
        st_nxt.flags = {b[7:1], 5'b00000};
        if (st_nxt.flags[FB_I]) begin
          st_nxt.phase = PH_PID;
        end else if (st_nxt.flags[FB_L]) begin
          st_nxt.phase = PH_LAYER;
        end else if (st_nxt.flags[FB_V]) begin
          st_nxt.phase = PH_SS;
        end else begin
          st_nxt.phase = PH_PAYLOAD;
          st_nxt.hdr   = st_nxt.bpos;
        end
      end
      PH_PID: begin
        st_nxt.pic = {8'h00, b[6:0]};
        if (b[7]) begin
          st_nxt.flags[FB_M] = 1'b1;
          st_nxt.phase       = PH_PIDEXT;
        end else if (st_nxt.flags[FB_L]) begin
          st_nxt.phase = PH_LAYER;
        end else if (st_nxt.flags[FB_V]) begin
          st_nxt.phase = PH_SS;
        end else begin
          st_nxt.phase = PH_PAYLOAD;
          st_nxt.hdr   = st_nxt.bpos;
        end
      end
      PH_PIDEXT: begin
        st_nxt.pic = {st_nxt.pic[6:0], b};
        if (st_nxt.flags[FB_L]) begin
          st_nxt.phase = PH_LAYER;
        end else if (st_nxt.flags[FB_V]) begin
          st_nxt.phase = PH_SS;
        end else begin
          st_nxt.phase = PH_PAYLOAD;
          st_nxt.hdr   = st_nxt.bpos;
        end
      end
      PH_LAYER: begin
        st_nxt.ids = {b[7:5], b[3:1]};
        if (b[4]) begin
          st_nxt.flags[FB_U] = 1'b1;
        end
        if (b[0]) begin
          st_nxt.flags[FB_D] = 1'b1;
        end
        st_nxt.phase = st_nxt.flags[FB_F] ? PH_PDIFF : PH_TL0;
      end
      PH_PDIFF: begin
        st_nxt.diff = b[7:1];
        if (st_nxt.dcnt < MAX_REF_DIFFS) begin
          st_nxt.dcnt = st_nxt.dcnt + 2'd1;
        end
        if (!b[0]) begin
          if (st_nxt.flags[FB_V]) begin
            st_nxt.phase = PH_SS;
          end else begin
            st_nxt.phase = PH_PAYLOAD;
            st_nxt.hdr   = st_nxt.bpos;
          end
        end else if (st_nxt.dcnt >= MAX_REF_DIFFS) begin
          // too many reference diffs ends the descriptor here
          st_nxt.err   = ST_DIFFS;
          st_nxt.hdr   = st_nxt.bpos;
          st_nxt.phase = PH_HALT;
        end
      end
      PH_TL0: begin
        st_nxt.tl0 = b;
        if (st_nxt.flags[FB_V]) begin
          st_nxt.phase = PH_SS;
        end else begin
          st_nxt.phase = PH_PAYLOAD;
          st_nxt.hdr   = st_nxt.bpos;
        end
      end
      PH_SS: begin
        st_nxt.ltot = b[7:5];
        if (b[4]) begin
          st_nxt.flags[FB_Y] = 1'b1;
        end
        if (b[3]) begin
          st_nxt.flags[FB_G] = 1'b1;
        end
        st_nxt.lcnt = 3'd0;
        st_nxt.sbc  = 2'd0;
        st_nxt.sacc = 24'd0;
        if (st_nxt.flags[FB_Y]) begin
          st_nxt.phase = PH_RES;
        end else if (st_nxt.flags[FB_G]) begin
          st_nxt.phase = PH_GOFN;
        end else begin
          st_nxt.phase = PH_PAYLOAD;
          st_nxt.hdr   = st_nxt.bpos;
        end
      end
      PH_RES: begin
        if (st_nxt.sbc == 2'd3) begin
          // fourth byte completes width and height
          res_emit                = 1'b1;
          res_rec.record_kind     = KIND_RES;
          res_rec.status          = st_nxt.err;
          res_rec.flag_bits       = st_nxt.flags;
          res_rec.picture_id      = st_nxt.pic;
          res_rec.temporal_id     = st_nxt.ids[5:3];
          res_rec.spatial_id      = st_nxt.ids[2:0];
          res_rec.tl0_index       = st_nxt.tl0;
          res_rec.reference_diff  = st_nxt.diff;
          res_rec.layer_number    = st_nxt.lcnt;
          res_rec.gof_frames      = 8'd0;
          res_rec.first_value     = st_nxt.sacc[23:8];
          res_rec.second_value    = {st_nxt.sacc[7:0], b};
          st_nxt.sbc  = 2'd0;
          st_nxt.sacc = 24'd0;
          if (st_nxt.lcnt == st_nxt.ltot) begin
            if (st_nxt.flags[FB_G]) begin
              st_nxt.phase = PH_GOFN;
            end else begin
              st_nxt.phase = PH_PAYLOAD;
              st_nxt.hdr   = st_nxt.bpos;
            end
          end else begin
            st_nxt.lcnt = st_nxt.lcnt + 3'd1;
          end
        end else begin
          st_nxt.sacc = {st_nxt.sacc[15:0], b};
          st_nxt.sbc  = st_nxt.sbc + 2'd1;
        end
      end
      PH_GOFN: begin
        st_nxt.gtot = b;
        st_nxt.gcnt = 8'd0;
        if (b == 8'd0) begin
          st_nxt.phase = PH_PAYLOAD;
          st_nxt.hdr   = st_nxt.bpos;
        end else begin
          st_nxt.phase = PH_GOFENT;
        end
      end
      PH_GOFENT: begin
        st_nxt.skip = b[3:2];
        if (b[3:2] != 2'd0) begin
          st_nxt.phase = PH_GOFSKIP;
        end else begin
          st_nxt.gcnt = st_nxt.gcnt + 8'd1;
          if (st_nxt.gcnt == st_nxt.gtot) begin
            st_nxt.phase = PH_PAYLOAD;
            st_nxt.hdr   = st_nxt.bpos;
          end else begin
            st_nxt.phase = PH_GOFENT;
          end
        end
      end
      PH_GOFSKIP: begin
        st_nxt.skip = st_nxt.skip - 2'd1;
        if (st_nxt.skip == 2'd0) begin
          st_nxt.gcnt = st_nxt.gcnt + 8'd1;
          if (st_nxt.gcnt == st_nxt.gtot) begin
            st_nxt.phase = PH_PAYLOAD;
            st_nxt.hdr   = st_nxt.bpos;
          end else begin
            st_nxt.phase = PH_GOFENT;
          end
        end
      end
      default: begin
      end
    endcase

    // packet end: descriptor record, then restart
    if (in_data.last_byte) begin
      if (st_nxt.phase != PH_PAYLOAD && st_nxt.phase != PH_HALT) begin
        st_nxt.err = ST_TRUNC;
        st_nxt.hdr = st_nxt.bpos;
      end
      desc_rec.record_kind    = KIND_DESC;
      desc_rec.status         = st_nxt.err;
      desc_rec.flag_bits      = st_nxt.flags;
      desc_rec.picture_id     = st_nxt.pic;
      desc_rec.temporal_id    = st_nxt.ids[5:3];
      desc_rec.spatial_id     = st_nxt.ids[2:0];
      desc_rec.tl0_index      = st_nxt.tl0;
      desc_rec.reference_diff = st_nxt.diff;
      desc_rec.layer_number   = st_nxt.ltot;
      desc_rec.gof_frames     = st_nxt.gtot;
      desc_rec.first_value    = st_nxt.hdr;
      desc_rec.second_value   = st_nxt.bpos - st_nxt.hdr;
      st_nxt       = '0;
      st_nxt.phase = PH_FLAG;
    end
  end

  // records for the queue, resolution ahead of descriptor
  always_comb begin
    push.cnt  = 2'd0;
    push.rec0 = res_emit ? res_rec : desc_rec;
    push.rec1 = desc_rec;
    if (acc) begin
      push.cnt = {1'b0, res_emit} + {1'b0, in_data.last_byte};
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_clr;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== src/vrd_queue.sv =====
module vrd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  vrd_pkg::push_t  push,
  input  logic            pop,
  output vrd_pkg::rec_t   head,
  output vrd_pkg::qstat_t qstat
);
  import vrd_pkg::*;

  rec_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  // pointers and fill level
  always_comb begin
    wp_nxt  = wp_r + QPTR_W'(push.cnt);
    rp_nxt  = rp_r + QPTR_W'(pop);
    cnt_nxt = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry writes, up to two per cycle
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wp_r] <= push.rec0;
    end
    if (push.cnt == 2'd2) begin
      q_r[wp_r + QPTR_W'(1)] <= push.rec1;
    end
  end

  assign head           = q_r[rp_r];
  assign qstat.count    = cnt_r;
  assign qstat.nonempty = (cnt_r != '0);
  // a byte may add two records
  assign qstat.room     = (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));

endmodule

// ===== src/vrd_back.sv =====
module vrd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  vrd_pkg::rec_t head,
  input  logic          nonempty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output vrd_pkg::rec_t out_data
);
  import vrd_pkg::*;

  logic out_valid_r, out_valid_nxt;
  rec_t out_data_r;

  // refill the output register when empty or on transfer
  assign pop           = nonempty && (!out_valid_r || out_ready);
  assign out_valid_nxt = pop || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= head;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/vp9_rtp_descriptor_parser.sv =====
// vp9 rtp payload descriptor parser, one payload byte per transfer
// throughput: one byte per cycle while in_ready is high; parse state is registered
// a completed record is registered in the queue, then in the output register
// in_ready drops while the record queue holds more than QUEUE_DEPTH-2 records
// reset: synchronous active-low rst_n clears parse state, queue and output register
`include "vp9_rtp_descriptor_parser_macros.svh"

module vp9_rtp_descriptor_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vrd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output vrd_pkg::rec_t out_data
);
  import vrd_pkg::*;

  push_t  push;
  rec_t   head;
  qstat_t qstat;
  logic   acc;
  logic   pop;

  // byte transfer
  assign in_ready = qstat.room;
  assign acc      = in_valid && in_ready;

  // front: parse and classify bytes
  vrd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_data (in_data),
    .push    (push)
  );

  // record queue
  vrd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // back: output register
  vrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .nonempty  (qstat.nonempty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  `VRD_ASSERT_NOW(a_queue_bound, 1'b1, qstat.count <= QCNT_W'(QUEUE_DEPTH), "record queue overflow")
  `VRD_ASSERT_NEXT(a_last_gives_record, acc && in_data.last_byte, qstat.nonempty || out_valid, "packet end left no record")
  `VRD_ASSERT_NOW(a_valid_drop, $fell(out_valid), $past(out_ready), "output record dropped without transfer")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import vrd_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RAND_BYTES    = 600;

  typedef struct {
    in_t  item;
    bit   typed;
    rec_t rec;
  } stim_row_t;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  rec_t out_data;

  // records the parser owes us, oldest first
  rec_t pending_recs[$];
  rec_t step_recs[$];
  rec_t want;
  int   fail_count  = 0;
  int   idle_cycles = 0;
  int   stall_left  = 0;
  bit   rx_quiet    = 1'b0;

  // descriptor parse state of the predictor
  phase_t      phase_q;
  logic [11:0] flags_q;
  logic [14:0] pic_q;
  logic [2:0]  tid_q;
  logic [2:0]  sid_q;
  logic [7:0]  tl0_q;
  logic [6:0]  diff_q;
  logic [1:0]  ndiff_q;
  logic [2:0]  ns_q;
  logic [2:0]  lidx_q;
  logic [1:0]  szb_q;
  logic [31:0] size_q;
  logic [7:0]  ng_q;
  logic [7:0]  gidx_q;
  logic [1:0]  skip_q;
  logic [15:0] pos_q;
  logic [15:0] hdr_q;
  logic [1:0]  status_q;

  vp9_rtp_descriptor_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_t mk_byte(logic [7:0] v, logic f, logic l);
    in_t r;
    r.data_byte  = v;
    r.first_byte = f;
    r.last_byte  = l;
    return r;
  endfunction

  function automatic stim_row_t row(logic [7:0] v, logic f, logic l, bit typed, rec_t r);
    stim_row_t s;
    s.item  = mk_byte(v, f, l);
    s.typed = typed;
    s.rec   = r;
    return s;
  endfunction

  // descriptor record with no scalability structure
  function automatic rec_t desc(logic [1:0] st, logic [11:0] fl, logic [14:0] pid,
                                logic [2:0] t, logic [2:0] s, logic [7:0] tl0,
                                logic [6:0] d, logic [15:0] hdr, logic [15:0] pay);
    rec_t r;
    r.record_kind    = KIND_DESC;
    r.status         = st;
    r.flag_bits      = fl;
    r.picture_id     = pid;
    r.temporal_id    = t;
    r.spatial_id     = s;
    r.tl0_index      = tl0;
    r.reference_diff = d;
    r.layer_number   = 3'd0;
    r.gof_frames     = 8'd0;
    r.first_value    = hdr;
    r.second_value   = pay;
    return r;
  endfunction

  function automatic rec_t make_rec(logic kind, logic [2:0] layer, logic [7:0] gof,
                                    logic [15:0] v1, logic [15:0] v2);
    rec_t r;
    r.record_kind    = kind;
    r.status         = status_q;
    r.flag_bits      = flags_q;
    r.picture_id     = pic_q;
    r.temporal_id    = tid_q;
    r.spatial_id     = sid_q;
    r.tl0_index      = tl0_q;
    r.reference_diff = diff_q;
    r.layer_number   = layer;
    r.gof_frames     = gof;
    r.first_value    = v1;
    r.second_value   = v2;
    return r;
  endfunction

  task automatic clear_state();
    phase_q  = PH_FLAG;
    flags_q  = '0;
    pic_q    = '0;
    tid_q    = '0;
    sid_q    = '0;
    tl0_q    = '0;
    diff_q   = '0;
    ndiff_q  = '0;
    ns_q     = '0;
    lidx_q   = '0;
    szb_q    = '0;
    size_q   = '0;
    ng_q     = '0;
    gidx_q   = '0;
    skip_q   = '0;
    pos_q    = '0;
    hdr_q    = '0;
    status_q = ST_OK;
  endtask

  task automatic close_header();
    phase_q = PH_PAYLOAD;
    hdr_q   = pos_q;
  endtask

  task automatic leave_layer_section();
    if (flags_q[FB_V]) phase_q = PH_SS;
    else close_header();
  endtask

  task automatic leave_id_section();
    if (flags_q[FB_L]) phase_q = PH_LAYER;
    else leave_layer_section();
  endtask

  task automatic leave_sizes();
    if (flags_q[FB_G]) phase_q = PH_GOFN;
    else close_header();
  endtask

  task automatic step_gof_frame();
    gidx_q = gidx_q + 8'd1;
    if (gidx_q == ng_q) close_header();
    else phase_q = PH_GOFENT;
  endtask

  // advance the descriptor parse by one byte, records land in step_recs
  task automatic parse_byte(input in_t it);
    logic [7:0] b;
    b = it.data_byte;
    step_recs.delete();
    if (it.first_byte) clear_state();
    if (pos_q != MAX_PACKET_BYTES) pos_q = pos_q + 16'd1;
    case (phase_q)
      PH_FLAG: begin
        flags_q = {b[7:1], 5'b0};
        if (flags_q[FB_I]) phase_q = PH_PID;
        else leave_id_section();
      end
      PH_PID: begin
        pic_q = {8'd0, b[6:0]};
        if (b[7]) begin
          flags_q[FB_M] = 1'b1;
          phase_q = PH_PIDEXT;
        end else begin
          leave_id_section();
        end
      end
      PH_PIDEXT: begin
        pic_q = {pic_q[6:0], b};
        leave_id_section();
      end
      PH_LAYER: begin
        tid_q = b[7:5];
        sid_q = b[3:1];
        if (b[4]) flags_q[FB_U] = 1'b1;
        if (b[0]) flags_q[FB_D] = 1'b1;
        phase_q = flags_q[FB_F] ? PH_PDIFF : PH_TL0;
      end
      PH_PDIFF: begin
        diff_q = b[7:1];
        if (ndiff_q < MAX_REF_DIFFS) ndiff_q = ndiff_q + 2'd1;
        if (!b[0]) begin
          leave_layer_section();
        end else if (ndiff_q >= MAX_REF_DIFFS) begin
          status_q = ST_DIFFS;
          hdr_q    = pos_q;
          phase_q  = PH_HALT;
        end
      end
      PH_TL0: begin
        tl0_q = b;
        leave_layer_section();
      end
      PH_SS: begin
        ns_q = b[7:5];
        if (b[4]) flags_q[FB_Y] = 1'b1;
        if (b[3]) flags_q[FB_G] = 1'b1;
        lidx_q = '0;
        szb_q  = '0;
        size_q = '0;
        if (flags_q[FB_Y]) phase_q = PH_RES;
        else leave_sizes();
      end
      PH_RES: begin
        size_q = {size_q[23:0], b};
        if (szb_q == 2'd3) begin
          szb_q = '0;
          step_recs.insert(step_recs.size(),
                           make_rec(KIND_RES, lidx_q, 8'd0, size_q[31:16], size_q[15:0]));
          size_q = '0;
          if (lidx_q == ns_q) leave_sizes();
          else lidx_q = lidx_q + 3'd1;
        end else begin
          szb_q = szb_q + 2'd1;
        end
      end
      PH_GOFN: begin
        ng_q   = b;
        gidx_q = '0;
        if (b == 8'd0) close_header();
        else phase_q = PH_GOFENT;
      end
      PH_GOFENT: begin
        skip_q = b[3:2];
        if (skip_q != 2'd0) phase_q = PH_GOFSKIP;
        else step_gof_frame();
      end
      PH_GOFSKIP: begin
        skip_q = skip_q - 2'd1;
        if (skip_q == 2'd0) step_gof_frame();
      end
      default: ;
    endcase
    // packet end always closes with a descriptor record
    if (it.last_byte) begin
      if (phase_q != PH_PAYLOAD && phase_q != PH_HALT) begin
        status_q = ST_TRUNC;
        hdr_q    = pos_q;
      end
      step_recs.insert(step_recs.size(),
                       make_rec(KIND_DESC, ns_q, ng_q, hdr_q, pos_q - hdr_q));
      clear_state();
    end
  endtask

  // one input transfer; called at the edge of the previous transfer
  task automatic drive_byte(input in_t it, input int gap, input bit typed, input rec_t rec);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    parse_byte(it);
    if (typed) begin
      pending_recs.insert(pending_recs.size(), rec);
    end else begin
      pending_recs = {pending_recs, step_recs};
    end
  endtask

  // hold the sender until every owed record has come out
  task automatic drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_recs.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string fname, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", fname, want_v, got_v);
      fail_count++;
    end
  endtask

  // result side: random stalls and record compare
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_recs.size() == 0) begin
          $error("unexpected record transfer, kind %0d", out_data.record_kind);
          fail_count++;
        end else begin
          want = pending_recs.pop_front();
          check_field("record_kind", 16'(want.record_kind), 16'(out_data.record_kind));
          check_field("status", 16'(want.status), 16'(out_data.status));
          check_field("flag_bits", 16'(want.flag_bits), 16'(out_data.flag_bits));
          check_field("picture_id", 16'(want.picture_id), 16'(out_data.picture_id));
          check_field("temporal_id", 16'(want.temporal_id), 16'(out_data.temporal_id));
          check_field("spatial_id", 16'(want.spatial_id), 16'(out_data.spatial_id));
          check_field("tl0_index", 16'(want.tl0_index), 16'(out_data.tl0_index));
          check_field("reference_diff", 16'(want.reference_diff),
                      16'(out_data.reference_diff));
          check_field("layer_number", 16'(want.layer_number), 16'(out_data.layer_number));
          check_field("gof_frames", 16'(want.gof_frames), 16'(out_data.gof_frames));
          check_field("first_value", want.first_value, out_data.first_value);
          check_field("second_value", want.second_value, out_data.second_value);
        end
        stall_left = rx_quiet ? 0 : $urandom_range(0, 8);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[vp9_rtp_descriptor_parser] ERROR");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t dir_rows[$];
    in_t       pkt_q[$];
    in_t       it;
    int        sent;
    int        kind;
    int        nd;
    int        ns;
    int        ng;
    int        cut;
    logic [7:0] fb;
    logic [7:0] pb;
    logic [7:0] ss;
    logic [7:0] eb;
    bit        tx_quiet;
    bit        need_first;
    bit        err;
    bit        fst;

    clear_state();
    sent       = 0;
    need_first = 1'b1;

    // packet dropped by a restart, then single-byte packets
    dir_rows.insert(dir_rows.size(), row(8'hC0, 1'b1, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'h00, 1'b1, 1'b1, 1'b1,
                    desc(ST_OK, 12'h000, 15'd0, 3'd0, 3'd0, 8'd0, 7'd0, 16'd1, 16'd0)));
    dir_rows.insert(dir_rows.size(), row(8'hFF, 1'b1, 1'b1, 1'b1,
                    desc(ST_TRUNC, 12'hFE0, 15'd0, 3'd0, 3'd0, 8'd0, 7'd0, 16'd1, 16'd0)));
    // flexible mode, extended picture id, one reference diff too many
    dir_rows.insert(dir_rows.size(), row(8'hB0, 1'b1, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'hAA, 1'b0, 1'b1, 1'b1,
                    desc(ST_DIFFS, 12'hB1C, 15'h7FFF, 3'd7, 3'd7, 8'd0, 7'h7F,
                         16'd7, 16'd1)));
    // tl0 mode with scalability structure, no first flag after the last byte
    dir_rows.insert(dir_rows.size(), row(8'hA2, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'h05, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'h00, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'h1F, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'h00, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'h00, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'h01, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'h04, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'h77, 1'b0, 1'b0, 1'b0, '0));
    dir_rows.insert(dir_rows.size(), row(8'h5A, 1'b0, 1'b1, 1'b0, '0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      drive_byte(dir_rows[k].item, $urandom_range(0, 8), dir_rows[k].typed, dir_rows[k].rec);
    end
    drain_pause();

    // random packets: mostly well formed, some cut short, restarted or noise
    while (sent < RAND_BYTES) begin
      pkt_q.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6)) begin
          pkt_q.insert(pkt_q.size(), mk_byte(8'($urandom_range(0, 255)),
                                             1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1))));
        end
        need_first = 1'b0;
      end else begin
        fb  = 8'($urandom_range(0, 255));
        fst = need_first || ($urandom_range(0, 3) != 0);
        pkt_q.insert(pkt_q.size(), mk_byte(fb, fst, 1'b0));
        // picture id
        if (fb[7]) begin
          pb = 8'($urandom_range(0, 255));
          pkt_q.insert(pkt_q.size(), mk_byte(pb, 1'b0, 1'b0));
          if (pb[7]) begin
            pkt_q.insert(pkt_q.size(), mk_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0));
          end
        end
        // layer byte, then reference diffs or tl0 index
        if (fb[5]) begin
          pkt_q.insert(pkt_q.size(), mk_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0));
          if (fb[4]) begin
            err = ($urandom_range(0, 5) == 0);
            nd  = err ? 3 : $urandom_range(1, 3);
            for (int j = 0; j < nd; j++) begin
              pb    = 8'($urandom_range(0, 255));
              pb[0] = err || (j < nd - 1);
              pkt_q.insert(pkt_q.size(), mk_byte(pb, 1'b0, 1'b0));
            end
          end else begin
            pkt_q.insert(pkt_q.size(), mk_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0));
          end
        end
        // scalability structure
        if (fb[1]) begin
          ss = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) != 0) ss[7:5] = 3'($urandom_range(0, 2));
          pkt_q.insert(pkt_q.size(), mk_byte(ss, 1'b0, 1'b0));
          ns = int'(ss[7:5]);
          if (ss[4]) begin
            repeat ((ns + 1) * 4) begin
              pkt_q.insert(pkt_q.size(), mk_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            end
          end
          if (ss[3]) begin
            ng = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 31) : $urandom_range(0, 3);
            pkt_q.insert(pkt_q.size(), mk_byte(8'(ng), 1'b0, 1'b0));
            repeat (ng) begin
              eb = 8'($urandom_range(0, 255));
              pkt_q.insert(pkt_q.size(), mk_byte(eb, 1'b0, 1'b0));
              repeat (eb[3:2]) begin
                pkt_q.insert(pkt_q.size(), mk_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0));
              end
            end
          end
        end
        repeat ($urandom_range(0, 6)) begin
          pkt_q.insert(pkt_q.size(), mk_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0));
        end
        // truncated or restarted packets lose their tail
        if (kind <= 2) begin
          cut = $urandom_range(1, pkt_q.size());
          while (pkt_q.size() > cut) void'(pkt_q.pop_back());
        end
        if (kind != 2) begin
          it = pkt_q.pop_back();
          it.last_byte = 1'b1;
          pkt_q.insert(pkt_q.size(), it);
        end
        need_first = (kind == 2);
      end

      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 15) == 0) drain_pause();
      foreach (pkt_q[k]) begin
        drive_byte(pkt_q[k], tx_quiet ? 0 : $urandom_range(0, 8), 1'b0, '0);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[vp9_rtp_descriptor_parser] OK");
    end else begin
      $display("[vp9_rtp_descriptor_parser] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/vrd_pkg.sv
src/vrd_front.sv
src/vrd_queue.sv
src/vrd_back.sv
src/vp9_rtp_descriptor_parser.sv
tb/sv/tb_top.sv
